### hdl/complex_arith_unit_core_defines.svh
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes and the control word that travels along the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cau_op_e;

  typedef struct packed {
    logic    valid;
    cau_op_e op;
    logic    neg_re;
    logic    neg_im;
    logic    dz;
  } cau_ctrl_t;

endpackage

### hdl/cau_div_cell.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider cell
// One restoring division step for the real and imaginary dividends.
// ----------------------------------------------------------------------------
module cau_div_cell #(
  parameter int NumW = 32,
  parameter int DvW  = 40,
  parameter int ByW  = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  cau_pkg::cau_ctrl_t ctrl_i,
  input  logic [NumW-1:0]    den_i,
  input  logic [DvW-1:0]     x_re_i,
  input  logic [DvW-1:0]     x_im_i,
  input  logic [NumW-1:0]    rem_re_i,
  input  logic [NumW-1:0]    rem_im_i,
  input  logic [ByW-1:0]     byp_re_i,
  input  logic [ByW-1:0]     byp_im_i,
  output cau_pkg::cau_ctrl_t ctrl_o,
  output logic [NumW-1:0]    den_o,
  output logic [DvW-1:0]     x_re_o,
  output logic [DvW-1:0]     x_im_o,
  output logic [NumW-1:0]    rem_re_o,
  output logic [NumW-1:0]    rem_im_o,
  output logic [ByW-1:0]     byp_re_o,
  output logic [ByW-1:0]     byp_im_o
);
  import cau_pkg::*;

  logic [NumW:0]   t_re, t_im, s_re, s_im;
  logic            ge_re, ge_im;
  logic [NumW-1:0] rem_re_d, rem_im_d;
  cau_ctrl_t       ctrl_q;
  logic [NumW-1:0] den_q, rem_re_q, rem_im_q;
  logic [DvW-1:0]  x_re_q, x_im_q;
  logic [ByW-1:0]  byp_re_q, byp_im_q;

  always_comb begin
    t_re     = {rem_re_i, x_re_i[DvW-1]};
    t_im     = {rem_im_i, x_im_i[DvW-1]};
    ge_re    = t_re >= {1'b0, den_i};
    ge_im    = t_im >= {1'b0, den_i};
    s_re     = t_re - {1'b0, den_i};
    s_im     = t_im - {1'b0, den_i};
    rem_re_d = ge_re ? s_re[NumW-1:0] : t_re[NumW-1:0];
    rem_im_d = ge_im ? s_im[NumW-1:0] : t_im[NumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q    <= den_i;
      rem_re_q <= rem_re_d;
      rem_im_q <= rem_im_d;
      x_re_q   <= {x_re_i[DvW-2:0], ge_re};
      x_im_q   <= {x_im_i[DvW-2:0], ge_im};
      byp_re_q <= byp_re_i;
      byp_im_q <= byp_im_i;
    end
  end

  assign ctrl_o   = ctrl_q;
  assign den_o    = den_q;
  assign x_re_o   = x_re_q;
  assign x_im_o   = x_im_q;
  assign rem_re_o = rem_re_q;
  assign rem_im_o = rem_im_q;
  assign byp_re_o = byp_re_q;
  assign byp_im_o = byp_im_q;

endmodule

### hdl/cau_sat.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit saturation
// Turns a sign and magnitude into a saturated two's complement value.
// ----------------------------------------------------------------------------
module cau_sat #(
  parameter int DataW = 16,
  parameter int MagW  = 41
) (
  input  logic             neg_i,
  input  logic [MagW-1:0]  mag_i,
  output logic [DataW-1:0] val_o,
  output logic             ovf_o
);

  logic [MagW-1:0] half, m, nm;

  always_comb begin
    half  = MagW'(1) << (DataW - 1);
    ovf_o = 1'b0;
    m     = mag_i;
    if (neg_i) begin
      if (mag_i > half) begin
        m     = half;
        ovf_o = 1'b1;
      end
    end else if (mag_i > half - MagW'(1)) begin
      m     = half - MagW'(1);
      ovf_o = 1'b1;
    end
    nm    = ~m + MagW'(1);
    val_o = neg_i ? nm[DataW-1:0] : m[DataW-1:0];
  end

endmodule

### hdl/complex_arith_unit_core.sv
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply and divide of complex fixed-point operands.
// ----------------------------------------------------------------------------
// The unit takes one transfer per clock unless the output is held and
// returns one result per transfer, in order. Every opcode takes one path:
// the product and sum register, the magnitude and denominator register, a row
// of 2*DATA_WIDTH + FRAC_BITS divider cells, one quotient bit per cell, and
// the saturating output register. The whole pipeline holds with a held output.
module complex_arith_unit_core #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8,
  localparam int InW  = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OutW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [InW-1:0]  s_axis_tdata,
  // req_type
  input  logic [1:0]      s_axis_tuser,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // result_real, result_imag
  output logic [OutW-1:0] m_axis_tdata,
  // overflow_flag, div_zero_flag
  output logic [1:0]      m_axis_tuser
);
  import cau_pkg::*;
  `include "complex_arith_unit_core_defines.svh"

  localparam int DW   = DATA_WIDTH;
  localparam int NumW = 2 * DW;
  localparam int DvW  = NumW + FRAC_BITS;
  localparam int SgW  = NumW + 1;
  localparam int MW   = DvW + 1;

  logic en;
  logic signed [DW-1:0] ar, ai, br, bi;
  logic signed [DW:0]   ar_x, ai_x, br_x, bi_x;

  cau_ctrl_t              s1_ctrl_q, s1_ctrl_d, s2_ctrl_q, s2_ctrl_d;
  logic signed [NumW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq_r_q, sq_i_q;
  logic signed [DW:0]     sum_re_q, sum_im_q, sum_re_d, sum_im_d;

  logic signed [SgW-1:0]  v_re, v_im;
  logic [SgW-1:0]         mag_re, mag_im;
  logic [NumW-1:0]        den_d, den_q;
  logic [DvW-1:0]         x_re_d, x_im_d, x_re_q, x_im_q;
  logic [SgW-1:0]         byp_re_d, byp_im_d, byp_re_q, byp_im_q;

  cau_ctrl_t       c_ctrl   [0:DvW];
  logic [NumW-1:0] c_den    [0:DvW];
  logic [DvW-1:0]  c_x_re   [0:DvW];
  logic [DvW-1:0]  c_x_im   [0:DvW];
  logic [NumW-1:0] c_rem_re [0:DvW];
  logic [NumW-1:0] c_rem_im [0:DvW];
  logic [SgW-1:0]  c_byp_re [0:DvW];
  logic [SgW-1:0]  c_byp_im [0:DvW];

  logic [MW-1:0]  f_mag_re, f_mag_im;
  logic [DW-1:0]  f_re, f_im;
  logic           f_ovf_re, f_ovf_im;
  logic           out_valid_q;
  logic [DW-1:0]  out_re_q, out_im_q;
  logic           out_ovf_q, out_dz_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  assign ar   = $signed(s_axis_tdata[DW-1:0]);
  assign ai   = $signed(s_axis_tdata[2*DW-1:DW]);
  assign br   = $signed(s_axis_tdata[3*DW-1:2*DW]);
  assign bi   = $signed(s_axis_tdata[4*DW-1:3*DW]);
  assign ar_x = (DW + 1)'(ar);
  assign ai_x = (DW + 1)'(ai);
  assign br_x = (DW + 1)'(br);
  assign bi_x = (DW + 1)'(bi);

  always_comb begin
    s1_ctrl_d       = '0;
    s1_ctrl_d.valid = s_axis_tvalid;
    s1_ctrl_d.op    = cau_op_e'(s_axis_tuser);
    if (s1_ctrl_d.op == OP_SUB) begin
      sum_re_d = ar_x - br_x;
      sum_im_d = ai_x - bi_x;
    end else begin
      sum_re_d = ar_x + br_x;
      sum_im_d = ai_x + bi_x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q <= '0;
      s2_ctrl_q <= '0;
    end else if (en) begin
      s1_ctrl_q <= s1_ctrl_d;
      s2_ctrl_q <= s2_ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_rr_q   <= ar * br;
      p_ii_q   <= ai * bi;
      p_ri_q   <= ar * bi;
      p_ir_q   <= ai * br;
      sq_r_q   <= br * br;
      sq_i_q   <= bi * bi;
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
      den_q    <= den_d;
      x_re_q   <= x_re_d;
      x_im_q   <= x_im_d;
      byp_re_q <= byp_re_d;
      byp_im_q <= byp_im_d;
    end
  end

  always_comb begin
    unique case (s1_ctrl_q.op)
      OP_ADD, OP_SUB: begin
        v_re = SgW'(sum_re_q);
        v_im = SgW'(sum_im_q);
      end
      OP_MUL: begin
        v_re = SgW'(p_rr_q) - SgW'(p_ii_q);
        v_im = SgW'(p_ri_q) + SgW'(p_ir_q);
      end
      default: begin
        v_re = SgW'(p_rr_q) + SgW'(p_ii_q);
        v_im = SgW'(p_ir_q) - SgW'(p_ri_q);
      end
    endcase
    mag_re = v_re[SgW-1] ? SgW'(-v_re) : SgW'(v_re);
    mag_im = v_im[SgW-1] ? SgW'(-v_im) : SgW'(v_im);
    den_d  = $unsigned(sq_r_q) + $unsigned(sq_i_q);
    x_re_d = DvW'(mag_re[NumW-1:0]) << FRAC_BITS;
    x_im_d = DvW'(mag_im[NumW-1:0]) << FRAC_BITS;

    s2_ctrl_d        = s1_ctrl_q;
    s2_ctrl_d.neg_re = v_re[SgW-1];
    s2_ctrl_d.neg_im = v_im[SgW-1];
    s2_ctrl_d.dz     = 1'b0;
    unique case (s1_ctrl_q.op)
      OP_ADD, OP_SUB: begin
        byp_re_d = mag_re;
        byp_im_d = mag_im;
      end
      OP_MUL: begin
        byp_re_d = mag_re >> FRAC_BITS;
        byp_im_d = mag_im >> FRAC_BITS;
      end
      default: begin
        byp_re_d = '0;
        byp_im_d = '0;
        if (den_d == '0) begin
          s2_ctrl_d.dz     = 1'b1;
          s2_ctrl_d.neg_re = 1'b0;
          s2_ctrl_d.neg_im = 1'b0;
        end
      end
    endcase
  end

  assign c_ctrl[0]   = s2_ctrl_q;
  assign c_den[0]    = den_q;
  assign c_x_re[0]   = x_re_q;
  assign c_x_im[0]   = x_im_q;
  assign c_rem_re[0] = '0;
  assign c_rem_im[0] = '0;
  assign c_byp_re[0] = byp_re_q;
  assign c_byp_im[0] = byp_im_q;

  for (genvar g = 0; g < DvW; g++) begin : g_cell
    cau_div_cell #(
      .NumW(NumW),
      .DvW (DvW),
      .ByW (SgW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctrl_i  (c_ctrl[g]),
      .den_i   (c_den[g]),
      .x_re_i  (c_x_re[g]),
      .x_im_i  (c_x_im[g]),
      .rem_re_i(c_rem_re[g]),
      .rem_im_i(c_rem_im[g]),
      .byp_re_i(c_byp_re[g]),
      .byp_im_i(c_byp_im[g]),
      .ctrl_o  (c_ctrl[g+1]),
      .den_o   (c_den[g+1]),
      .x_re_o  (c_x_re[g+1]),
      .x_im_o  (c_x_im[g+1]),
      .rem_re_o(c_rem_re[g+1]),
      .rem_im_o(c_rem_im[g+1]),
      .byp_re_o(c_byp_re[g+1]),
      .byp_im_o(c_byp_im[g+1])
    );
  end

  always_comb begin
    if (c_ctrl[DvW].dz) begin
      f_mag_re = '0;
      f_mag_im = '0;
    end else if (c_ctrl[DvW].op == OP_DIV) begin
      f_mag_re = MW'(c_x_re[DvW]);
      f_mag_im = MW'(c_x_im[DvW]);
    end else begin
      f_mag_re = MW'(c_byp_re[DvW]);
      f_mag_im = MW'(c_byp_im[DvW]);
    end
  end

  cau_sat #(.DataW(DW), .MagW(MW)) u_sat_re (
    .neg_i(c_ctrl[DvW].neg_re),
    .mag_i(f_mag_re),
    .val_o(f_re),
    .ovf_o(f_ovf_re)
  );

  cau_sat #(.DataW(DW), .MagW(MW)) u_sat_im (
    .neg_i(c_ctrl[DvW].neg_im),
    .mag_i(f_mag_im),
    .val_o(f_im),
    .ovf_o(f_ovf_im)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_ctrl[DvW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_re_q  <= f_re;
      out_im_q  <= f_im;
      out_ovf_q <= f_ovf_re || f_ovf_im;
      out_dz_q  <= c_ctrl[DvW].dz;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_im_q, out_re_q});
  assign m_axis_tuser  = {out_dz_q, out_ovf_q};

  `CAU_ASSERT_SAME(a_dz_zero, out_valid_q && out_dz_q, (out_re_q == '0) && (out_im_q == '0) && !out_ovf_q, "divide by zero result not clean")
  `CAU_ASSERT_SAME(a_ovf_sat, out_valid_q && out_ovf_q, (out_re_q == {1'b0, {(DW-1){1'b1}}}) || (out_re_q == {1'b1, {(DW-1){1'b0}}}) || (out_im_q == {1'b0, {(DW-1){1'b1}}}) || (out_im_q == {1'b1, {(DW-1){1'b0}}}), "overflow without saturated part")
  `CAU_ASSERT_NEXT(a_tail_to_out, en && c_ctrl[DvW].valid, out_valid_q, "pipeline item lost at output")
  `CAU_ASSERT_NEXT(a_hold, !en, $stable(c_ctrl[DvW]) && $stable(s1_ctrl_q), "pipeline moved while stalled")

endmodule
